@@ src/rcr_pkg.sv @@
package rcr_pkg;

  // Canvas store geometry
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int USED_W     = (COL_W > ROW_W ? COL_W : ROW_W) + 1;
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;

  // Item and register field widths
  localparam int OP_W    = 2;
  localparam int COORD_W = 20;
  localparam int CHAR_W  = 8;
  localparam int PIX_W   = 9;
  localparam int SIZE_W  = 10;
  localparam int CFG_W   = 10;
  localparam int IDX_W   = 2;

  // Fixed-point compare width: Q12.8 sums plus scaled pixel positions
  localparam int FRAC_W = 8;
  localparam int QW     = 24;
  localparam logic signed [QW-1:0] ONE_Q = QW'(1 << FRAC_W);

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(300);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(300);
  localparam logic [CHAR_W-1:0] BG_RESET     = CHAR_W'(32);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [IDX_W-1:0] {
    REG_CANVAS_WIDTH  = 2'd0,
    REG_CANVAS_HEIGHT = 2'd1,
    REG_BACKGROUND    = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SWEEP,
    ST_READ,
    ST_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic idle;
    logic sweep_start;
    logic sweep_step;
    logic rd_en;
    logic load_out;
  } rcr_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            bad;
    logic            empty;
    logic            last;
    logic            out_free;
  } rcr_status_t;

endpackage

@@ src/rectangle_canvas_rasterizer_top.sv @@
// Rectangle canvas rasterizer. Holds a 512 x 512 character canvas, of which
// canvas_width columns and canvas_height rows are in use (sizes above 512
// saturate, zero means empty). A clear beat fills every cell in use with the
// background character; a draw beat paints each integer pixel of the closed
// Q12.8 rectangle, or in outline mode only pixels less than 1.0 from an edge;
// a read beat returns one cell (0 outside the canvas). Every input beat gives
// exactly one result beat. The canvas memory has a single port, so clear and
// draw walk all cells in use one per cycle. One item is worked at a time;
// the next beat is taken as soon as the result is parked in the output
// register. Canvas cells power up unknown: read only cells that a clear or
// draw has written. Write configuration only while idle.
module rectangle_canvas_rasterizer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [rcr_pkg::IDX_W-1:0]           cfg_index_i,
  input  logic [rcr_pkg::CFG_W-1:0]           cfg_data_i,
  // input beats
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rcr_pkg::OP_W-1:0]            operation_i,
  input  logic signed [rcr_pkg::COORD_W-1:0]  rect_x_i,
  input  logic signed [rcr_pkg::COORD_W-1:0]  rect_y_i,
  input  logic signed [rcr_pkg::COORD_W-1:0]  rect_width_i,
  input  logic signed [rcr_pkg::COORD_W-1:0]  rect_height_i,
  input  logic                                filled_i,
  input  logic [rcr_pkg::CHAR_W-1:0]          paint_char_i,
  input  logic [rcr_pkg::PIX_W-1:0]           pixel_x_i,
  input  logic [rcr_pkg::PIX_W-1:0]           pixel_y_i,
  // result beats
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rcr_pkg::CHAR_W-1:0]          pixel_char_o,
  output logic                                bad_shape_o
);
  import rcr_pkg::*;

  rcr_cmd_t    cmd;
  rcr_status_t status;

  // Sequencer: decode the beat, run the sweep or read, hand off the result
  rcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Registers, sweep counters, rectangle test, canvas memory, result register
  rcr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .operation_i   (operation_i),
    .rect_x_i      (rect_x_i),
    .rect_y_i      (rect_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .filled_i      (filled_i),
    .paint_char_i  (paint_char_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .pixel_char_o  (pixel_char_o),
    .bad_shape_o   (bad_shape_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

@@ src/rcr_ctrl.sv @@
module rcr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rcr_pkg::rcr_status_t status_i,
  output rcr_pkg::rcr_cmd_t    cmd_o
);
  import rcr_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (status_i.op)
          OP_CLEAR: state_d = status_i.empty ? ST_RESULT : ST_SWEEP;
          OP_DRAW:  state_d = (status_i.bad || status_i.empty) ? ST_RESULT : ST_SWEEP;
          OP_READ:  state_d = ST_READ;
          default:  state_d = ST_RESULT;
        endcase
      end
      ST_SWEEP: begin
        if (status_i.last) state_d = ST_RESULT;
      end
      ST_READ:   state_d = ST_RESULT;
      ST_RESULT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o             = '0;
    in_stall_o        = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.idle = 1'b1;
        in_stall_o = 1'b0;
      end
      ST_DECODE: cmd_o.sweep_start = 1'b1;
      ST_SWEEP:  cmd_o.sweep_step = 1'b1;
      ST_READ:   cmd_o.rd_en = 1'b1;
      ST_RESULT: cmd_o.load_out = status_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == ST_DECODE)
    else $error("accepted beat did not move to decode");

  a_sweep_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && status_i.last) |=> state_q == ST_RESULT)
    else $error("sweep did not end after last cell");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_RESULT))
    else $error("read did not go to result");

endmodule

@@ src/rcr_dp.sv @@
module rcr_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rcr_pkg::IDX_W-1:0]            cfg_index_i,
  input  logic [rcr_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic [rcr_pkg::OP_W-1:0]             operation_i,
  input  logic signed [rcr_pkg::COORD_W-1:0]   rect_x_i,
  input  logic signed [rcr_pkg::COORD_W-1:0]   rect_y_i,
  input  logic signed [rcr_pkg::COORD_W-1:0]   rect_width_i,
  input  logic signed [rcr_pkg::COORD_W-1:0]   rect_height_i,
  input  logic                                 filled_i,
  input  logic [rcr_pkg::CHAR_W-1:0]           paint_char_i,
  input  logic [rcr_pkg::PIX_W-1:0]            pixel_x_i,
  input  logic [rcr_pkg::PIX_W-1:0]            pixel_y_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [rcr_pkg::CHAR_W-1:0]           pixel_char_o,
  output logic                                 bad_shape_o,
  input  rcr_pkg::rcr_cmd_t                    cmd_i,
  output rcr_pkg::rcr_status_t                 status_o
);
  import rcr_pkg::*;

  // Configuration registers
  logic [SIZE_W-1:0] cfg_width_q, cfg_height_q;
  logic [CHAR_W-1:0] bg_char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WIDTH_RESET;
      cfg_height_q <= HEIGHT_RESET;
      bg_char_q    <= BG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CANVAS_WIDTH:  cfg_width_q  <= cfg_data_i[SIZE_W-1:0];
        REG_CANVAS_HEIGHT: cfg_height_q <= cfg_data_i[SIZE_W-1:0];
        REG_BACKGROUND:    bg_char_q    <= cfg_data_i[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate sizes to the store
  logic [USED_W-1:0] used_cols, used_rows;
  assign used_cols = (32'(cfg_width_q) > MAX_WIDTH) ? USED_W'(MAX_WIDTH)
                                                    : USED_W'(cfg_width_q);
  assign used_rows = (32'(cfg_height_q) > MAX_HEIGHT) ? USED_W'(MAX_HEIGHT)
                                                      : USED_W'(cfg_height_q);

  // Item capture
  logic [OP_W-1:0]        op_q;
  logic signed [QW-1:0]   left_q, top_q, right_q, bottom_q;
  logic                   bad_q, fill_q;
  logic [CHAR_W-1:0]      paint_q;
  logic [PIX_W-1:0]       pix_x_q, pix_y_q;
  logic                   capture;

  assign capture = cmd_i.idle && in_valid_i;

  always_ff @(posedge clk_i) begin
    if (capture) begin
      op_q     <= operation_i;
      left_q   <= QW'(rect_x_i);
      top_q    <= QW'(rect_y_i);
      right_q  <= QW'(rect_x_i) + QW'(rect_width_i);
      bottom_q <= QW'(rect_y_i) + QW'(rect_height_i);
      bad_q    <= (rect_width_i <= 0) || (rect_height_i <= 0);
      fill_q   <= filled_i;
      paint_q  <= paint_char_i;
      pix_x_q  <= pixel_x_i;
      pix_y_q  <= pixel_y_i;
    end
  end

  // Sweep counters
  logic [COL_W-1:0] px_q, px_d;
  logic [ROW_W-1:0] py_q, py_d;
  logic             last_col, last_row;

  assign last_col = (USED_W'(px_q) + USED_W'(1)) == used_cols;
  assign last_row = (USED_W'(py_q) + USED_W'(1)) == used_rows;

  always_comb begin
    px_d = px_q;
    py_d = py_q;
    if (cmd_i.sweep_start) begin
      px_d = '0;
      py_d = '0;
    end else if (cmd_i.sweep_step) begin
      if (last_col) begin
        px_d = '0;
        py_d = py_q + ROW_W'(1);
      end else begin
        px_d = px_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
    end else begin
      px_q <= px_d;
      py_q <= py_d;
    end
  end

  // Pixel test against the closed rectangle, scaled by 256
  logic signed [QW-1:0] qx, qy;
  logic                 in_rect, on_edge, paint_hit;

  assign qx = {{(QW - COL_W - FRAC_W){1'b0}}, px_q, {FRAC_W{1'b0}}};
  assign qy = {{(QW - ROW_W - FRAC_W){1'b0}}, py_q, {FRAC_W{1'b0}}};

  assign in_rect = (qx >= left_q) && (qx <= right_q) && (qy >= top_q) && (qy <= bottom_q);
  assign on_edge = ((qx - left_q) < ONE_Q) || ((right_q - qx) < ONE_Q) ||
                   ((qy - top_q) < ONE_Q) || ((bottom_q - qy) < ONE_Q);
  assign paint_hit = in_rect && (fill_q || on_edge);

  // Canvas store: one write or one read a cycle
  logic [CHAR_W-1:0] canvas_mem [MEM_DEPTH];
  logic [CHAR_W-1:0] rdata_q;
  logic              mem_we;
  logic [CHAR_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] waddr, raddr;

  assign mem_we    = cmd_i.sweep_step &&
                     ((op_q == OP_CLEAR) || ((op_q == OP_DRAW) && paint_hit));
  assign mem_wdata = (op_q == OP_CLEAR) ? bg_char_q : paint_q;
  assign waddr     = {py_q, px_q};
  assign raddr     = {ROW_W'(pix_y_q), COL_W'(pix_x_q)};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      canvas_mem[waddr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= canvas_mem[raddr];
    end
  end

  // Result register
  logic              out_valid_q;
  logic [CHAR_W-1:0] pixel_char_q;
  logic              bad_shape_q;
  logic              read_in_range;

  assign read_in_range = (USED_W'(pix_x_q) < used_cols) && (USED_W'(pix_y_q) < used_rows);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pixel_char_q <= ((op_q == OP_READ) && read_in_range) ? rdata_q : '0;
      bad_shape_q  <= (op_q == OP_DRAW) && bad_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_char_o = pixel_char_q;
  assign bad_shape_o  = bad_shape_q;

  assign status_o.op       = op_q;
  assign status_o.bad      = bad_q;
  assign status_o.empty    = (used_cols == '0) || (used_rows == '0);
  assign status_o.last     = last_col && last_row;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a held beat");

  a_bad_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(bad_shape_q && (pixel_char_q != '0)))
    else $error("bad shape result carries a character");

  a_write_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((op_q == OP_CLEAR) || (op_q == OP_DRAW && !bad_q)))
    else $error("canvas written outside a clear or good draw");

endmodule

@@ bench/testbench.sv @@
// Testbench for the rectangle canvas rasterizer.
//
// A shadow copy of the canvas and of the three size/background registers is
// kept here. Every accepted input beat is run through the shadow rasterizer,
// and the result it yields is queued. The result checker pops that queue on
// every accepted result beat and compares both fields.
//
// Run time is dominated by the one-cell-per-cycle sweep of clear and draw, so
// the large canvases (reset size, full 512 x 512) appear only in the opening
// tests. The full-size clear also writes every cell of the store, so no
// later read can touch a cell that was never written.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rcr_pkg::*;

  // The unused operation code; the package names only the three real ones.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int ONE_PIXEL = 1 << FRAC_W;
  localparam int IDLE_PCT  = 6;
  localparam int SETTLE    = 8;
  // Longest quiet stretch of a correct run is one full-canvas sweep plus a
  // long receiver hold-off; allow four times that.
  localparam int WATCHDOG_LIMIT = 4 * (MEM_DEPTH + 1024);
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 10;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    logic [COORD_W-1:0] rw;
    logic [COORD_W-1:0] rh;
    logic               filled;
    logic [CHAR_W-1:0]  ch;
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
  } canvas_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] pixel_char;
    logic              bad_shape;
  } canvas_result_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Block inputs, all known from time zero
  logic               cfg_we    = 1'b0;
  cfg_reg_e           cfg_index = REG_CANVAS_WIDTH;
  logic [CFG_W-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic [OP_W-1:0]    operation = '0;
  logic [COORD_W-1:0] rect_x    = '0;
  logic [COORD_W-1:0] rect_y    = '0;
  logic [COORD_W-1:0] rect_w    = '0;
  logic [COORD_W-1:0] rect_h    = '0;
  logic               filled    = 1'b0;
  logic [CHAR_W-1:0]  paint     = '0;
  logic [PIX_W-1:0]   pix_x     = '0;
  logic [PIX_W-1:0]   pix_y     = '0;
  logic               out_stall = 1'b0;

  // Block outputs
  logic              in_stall_o;
  logic              out_valid_o;
  logic [CHAR_W-1:0] pixel_char_o;
  logic              bad_shape_o;

  rectangle_canvas_rasterizer_top u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation),
    .rect_x_i      (rect_x),
    .rect_y_i      (rect_y),
    .rect_width_i  (rect_w),
    .rect_height_i (rect_h),
    .filled_i      (filled),
    .paint_char_i  (paint),
    .pixel_x_i     (pix_x),
    .pixel_y_i     (pix_y),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .pixel_char_o  (pixel_char_o),
    .bad_shape_o   (bad_shape_o)
  );

  // Shadow state: canvas cells and the register copies
  logic [CHAR_W-1:0] canvas_shadow [MEM_DEPTH];
  logic [SIZE_W-1:0] shadow_cols = WIDTH_RESET;
  logic [SIZE_W-1:0] shadow_rows = HEIGHT_RESET;
  logic [CHAR_W-1:0] shadow_bg   = BG_RESET;

  canvas_result_t pending_results [$];
  int             error_count = 0;
  // Set during a stretch in which neither side idles.
  bit             calm = 1'b0;
  // Handed to the result sink to request a long hold-off, in cycles.
  int             hold_len = 0;

  function automatic int cols_in_use();
    return (shadow_cols > MAX_WIDTH) ? MAX_WIDTH : int'(shadow_cols);
  endfunction

  function automatic int rows_in_use();
    return (shadow_rows > MAX_HEIGHT) ? MAX_HEIGHT : int'(shadow_rows);
  endfunction

  // Shadow rasterizer: apply one beat to the shadow canvas, return its result.
  // All edge tests are on integers, pixel positions scaled to Q.8.
  function automatic canvas_result_t rasterize_item(canvas_item_t it);
    canvas_result_t res;
    int cols, rows, rx, ry, rw, rh, right, bottom, qx, qy;
    logic on_edge;
    res  = '0;
    cols = cols_in_use();
    rows = rows_in_use();
    if (it.op == OP_CLEAR) begin
      for (int y = 0; y < rows; y++)
        for (int x = 0; x < cols; x++)
          canvas_shadow[y * MAX_WIDTH + x] = shadow_bg;
    end else if (it.op == OP_DRAW) begin
      rx = $signed(it.rx);
      ry = $signed(it.ry);
      rw = $signed(it.rw);
      rh = $signed(it.rh);
      if (rw <= 0 || rh <= 0) begin
        res.bad_shape = 1'b1;
      end else begin
        right  = rx + rw;
        bottom = ry + rh;
        for (int y = 0; y < rows; y++) begin
          qy = y * ONE_PIXEL;
          if (qy >= ry && qy <= bottom) begin
            for (int x = 0; x < cols; x++) begin
              qx = x * ONE_PIXEL;
              if (qx >= rx && qx <= right) begin
                on_edge = (qx - rx < ONE_PIXEL) || (right - qx < ONE_PIXEL) ||
                          (qy - ry < ONE_PIXEL) || (bottom - qy < ONE_PIXEL);
                if (it.filled || on_edge)
                  canvas_shadow[y * MAX_WIDTH + x] = it.ch;
              end
            end
          end
        end
      end
    end else if (it.op == OP_READ) begin
      if (int'(it.px) < cols && int'(it.py) < rows)
        res.pixel_char = canvas_shadow[int'(it.py) * MAX_WIDTH + int'(it.px)];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Offer one beat and hold it until accepted. Called at a falling edge and
  // returns at the falling edge after acceptance with valid still high, so
  // the next call (or end_burst) must follow at once.
  task automatic send_item(canvas_item_t it);
    int gap;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= it.op;
    rect_x    <= it.rx;
    rect_y    <= it.ry;
    rect_w    <= it.rw;
    rect_h    <= it.rh;
    filled    <= it.filled;
    paint     <= it.ch;
    pix_x     <= it.px;
    pix_y     <= it.py;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    pending_results.push_back(rasterize_item(it));
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic drain();
    end_burst();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write all three registers, one per cycle, with the block idle.
  task automatic set_canvas(int cols, int rows, logic [CHAR_W-1:0] bg);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CANVAS_WIDTH;
    cfg_data  <= CFG_W'(cols);
    @(negedge clk);
    cfg_index <= REG_CANVAS_HEIGHT;
    cfg_data  <= CFG_W'(rows);
    @(negedge clk);
    // upper data bits are don't-care for the background register
    cfg_index <= REG_BACKGROUND;
    cfg_data  <= {2'($urandom()), bg};
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_cols = SIZE_W'(cols);
    shadow_rows = SIZE_W'(rows);
    shadow_bg   = bg;
  endtask

  task automatic send_op(logic [OP_W-1:0] op);
    canvas_item_t it;
    it    = '0;
    it.op = op;
    send_item(it);
  endtask

  task automatic read_cell(int x, int y);
    canvas_item_t it;
    it    = '0;
    it.op = OP_READ;
    it.px = PIX_W'(x);
    it.py = PIX_W'(y);
    send_item(it);
  endtask

  task automatic draw_rect(int rx, int ry, int rw, int rh, bit fill, logic [CHAR_W-1:0] ch);
    canvas_item_t it;
    it        = '0;
    it.op     = OP_DRAW;
    it.rx     = COORD_W'(rx);
    it.ry     = COORD_W'(ry);
    it.rw     = COORD_W'(rw);
    it.rh     = COORD_W'(rh);
    it.filled = fill;
    it.ch     = ch;
    send_item(it);
  endtask

  // Random beat for a canvas of the given size. Every field starts fully
  // random so unused fields toggle too; most draws land on the canvas.
  function automatic canvas_item_t random_item(int cols, int rows);
    canvas_item_t it;
    logic [127:0] raw_bits;
    int kind, c, r;
    c        = (cols < 1) ? 1 : cols;
    r        = (rows < 1) ? 1 : rows;
    raw_bits = {$urandom(), $urandom(), $urandom(), $urandom()};
    it       = raw_bits[$bits(canvas_item_t)-1:0];
    kind     = $urandom_range(99);
    if (kind < 6) begin
      it.op = OP_CLEAR;
    end else if (kind < 10) begin
      it.op = OP_UNUSED;
    end else if (kind < 55) begin
      it.op = OP_DRAW;
      it.rx = COORD_W'(int'($urandom_range(0, (c + 4) * ONE_PIXEL)) - 2 * ONE_PIXEL);
      it.ry = COORD_W'(int'($urandom_range(0, (r + 4) * ONE_PIXEL)) - 2 * ONE_PIXEL);
      it.rw = COORD_W'($urandom_range(1, (c + 2) * ONE_PIXEL));
      it.rh = COORD_W'($urandom_range(1, (r + 2) * ONE_PIXEL));
    end else if (kind < 63) begin
      // non-positive width, height or both
      it.op = OP_DRAW;
      case ($urandom_range(2))
        0: it.rw = COORD_W'(-int'($urandom_range(0, 524288)));
        1: it.rh = COORD_W'(-int'($urandom_range(0, 524288)));
        default: begin
          it.rw = COORD_W'(-int'($urandom_range(0, 524288)));
          it.rh = COORD_W'(-int'($urandom_range(0, 524288)));
        end
      endcase
    end else if (kind < 71) begin
      it.op = OP_DRAW;  // raw fields, anywhere in the Q12.8 range
    end else begin
      it.op = OP_READ;
      if ($urandom_range(99) < 75) begin
        it.px = PIX_W'((c > MAX_WIDTH - 1) ? $urandom_range(0, MAX_WIDTH - 1)
                                           : $urandom_range(0, c));
        it.py = PIX_W'((r > MAX_HEIGHT - 1) ? $urandom_range(0, MAX_HEIGHT - 1)
                                            : $urandom_range(0, r));
      end
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Registers as they come out of reset: 300 x 300, background space.
  task automatic test_reset_values();
    send_op(OP_CLEAR);
    read_cell(0, 0);
    read_cell(299, 299);
    read_cell(300, 5);     // one past the last column
    drain();
  endtask

  // Oversized width saturates to the full store; this clear also writes
  // every cell, so all later reads hit written cells.
  task automatic test_full_canvas();
    set_canvas(1023, MAX_HEIGHT, 8'hFF);
    send_op(OP_CLEAR);
    read_cell(511, 511);
    read_cell(0, 0);
    drain();
  endtask

  task automatic test_directed_draws();
    set_canvas(24, 16, 8'h2E);
    send_op(OP_CLEAR);
    // filled 5 x 3 at (2,1); closed rectangle includes column 7 and row 4
    draw_rect(32'h200, 32'h100, 32'h500, 32'h300, 1'b1, 8'h41);
    read_cell(7, 4);
    read_cell(8, 4);
    // outline with fractional edges: edge, interior and far corner
    draw_rect(32'hA80, 32'h240, 32'h800, 32'h600, 1'b0, 8'h42);
    read_cell(11, 3);
    read_cell(14, 5);
    read_cell(18, 8);
    // huge rectangle: outline misses the whole canvas, filled covers it
    draw_rect(-1024, -1024, 524287, 524287, 1'b0, 8'h44);
    read_cell(23, 15);
    draw_rect(-1024, -1024, 524287, 524287, 1'b1, 8'hC3);
    read_cell(0, 0);
    // extremes of the coordinate range, off canvas either way
    draw_rect(524287, -524288, 1, 524287, 1'b1, 8'h00);
    // smallest shape: a single pixel
    draw_rect(32'h300, 32'h300, 1, 1, 1'b0, 8'h45);
    read_cell(3, 3);
    // bad shapes leave the canvas alone
    draw_rect(0, 0, 0, 32'h400, 1'b1, 8'h5A);
    draw_rect(0, 0, 32'h400, 0, 1'b1, 8'h5A);
    draw_rect(0, 0, -524288, 32'h400, 1'b0, 8'h5A);
    draw_rect(0, 0, 32'h400, -1, 1'b0, 8'h5A);
    read_cell(1, 1);
    send_op(OP_UNUSED);
    read_cell(511, 511);
    drain();
  endtask

  // Empty and one-cell canvases, tall canvas, and a size change with no clear.
  task automatic test_canvas_sizes();
    set_canvas(0, 7, 8'h21);
    send_op(OP_CLEAR);
    draw_rect(0, 0, 32'h400, 32'h400, 1'b1, 8'h77);
    read_cell(0, 0);
    set_canvas(5, 0, 8'h22);
    send_op(OP_CLEAR);
    read_cell(0, 0);
    set_canvas(1, 1, 8'h23);
    send_op(OP_CLEAR);
    read_cell(0, 0);
    read_cell(1, 0);
    set_canvas(2, 1023, 8'h24);
    send_op(OP_CLEAR);
    read_cell(1, 511);
    // cells keep their addresses across a resize
    set_canvas(32, 20, 8'h25);
    read_cell(31, 19);
    read_cell(23, 15);
    drain();
  endtask

  // Hold the receiver off while beats keep coming, so the block fills up and
  // stalls its input.
  task automatic test_backpressure();
    set_canvas(8, 6, 8'h2D);
    hold_len = 400;
    send_op(OP_CLEAR);
    draw_rect(32'h100, 32'h100, 32'h300, 32'h200, 1'b0, 8'h6F);
    for (int i = 0; i < 8; i++)
      read_cell($urandom_range(0, 8), $urandom_range(0, 6));
    drain();
  endtask

  task automatic test_random_items();
    int r, cols, rows;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      r = $urandom_range(99);
      if (r < 10) begin
        cols = $urandom_range(MAX_WIDTH + 1, 1023);
        rows = $urandom_range(1, 3);
      end else if (r < 20) begin
        cols = $urandom_range(1, 3);
        rows = $urandom_range(MAX_HEIGHT + 1, 1023);
      end else if (r < 25) begin
        cols = 0;
        rows = $urandom_range(0, 40);
      end else begin
        cols = $urandom_range(1, 40);
        rows = $urandom_range(1, 40);
      end
      set_canvas(cols, rows, 8'($urandom()));
      // one phase runs with no idling on either side
      calm = (ph == 2);
      send_op(OP_CLEAR);
      for (int i = 1; i < PHASE_ITEMS; i++)
        send_item(random_item(cols_in_use(), rows_in_use()));
      drain();
      calm = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // Drive the receiver stall: random idling, or a requested long hold.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    canvas_result_t want;
    if (out_valid_o && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected, pixel_char", pixel_char_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (pixel_char_o !== want.pixel_char)
          report_mismatch("pixel_char", pixel_char_o, want.pixel_char);
        if (bad_shape_o !== want.bad_shape)
          report_mismatch("bad_shape", bad_shape_o, want.bad_shape);
      end
    end
  end

  // End the run if no beat moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main_sequence
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(negedge clk);
    test_reset_values();
    test_full_canvas();
    test_directed_draws();
    test_canvas_sizes();
    test_backpressure();
    test_random_items();
    drain();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
